// ===== design/jhtb_pkg.sv =====
// jhtb_pkg: shared types, widths and codes for the jpeg huffman table builder
// no dependencies; imported by the top level
`default_nettype none

package jhtb_pkg;

    localparam int MAX_CODE_LENGTH = 16;
    localparam int MAX_SYMBOLS     = 256;

    localparam int SYM_W     = $clog2(MAX_SYMBOLS);
    localparam int VAL_W     = SYM_W + 1;
    localparam int COUNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int LEN_W     = $clog2(MAX_CODE_LENGTH + 1) + 1;
    localparam int LIDX_W    = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
    localparam int RCODE_W   = MAX_CODE_LENGTH + 1;
    localparam int VBITS_W   = 4;
    localparam int ECODE_W   = 31;
    localparam int ESIZE_W   = 5;
    localparam int ENTRY_W   = ECODE_W + ESIZE_W;
    localparam int CFG_W     = SYM_W;

    localparam logic [LEN_W-1:0]   LEN_LAST   = LEN_W'(MAX_CODE_LENGTH);
    localparam logic [COUNT_W:0]   SYM_LIMIT  = (COUNT_W + 1)'(MAX_SYMBOLS);

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_COUNT  = 2'd1,
        REQ_SYMBOL = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_OVERRUN  = 3'd1,
        ERR_OVERFLOW = 3'd2,
        ERR_RANGE    = 3'd3,
        ERR_DUP      = 3'd4,
        ERR_ORDER    = 3'd5
    } err_t;

    typedef enum logic {
        CFG_TABLE_KIND = 1'b0,
        CFG_MAX_SYMBOL = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== design/jhtb_ram.sv =====
// jhtb_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module jhtb_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/jpeg_huffman_table_builder_unit.sv =====
// jpeg_huffman_table_builder_unit: canonical huffman encode table builder, top level
// depends on jhtb_pkg and jhtb_ram
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tuser: req_type; tdata: item_value
// m_       out  m_tvalid/m_tready  tdata: code_bits, code_size, entry_present,
//                                         table_valid, load_error
// cfg_     in   cfg_wr_en          cfg_index, cfg_data
//
// start and most count items go straight to the output register; a symbol may first run
// the length search over the code lengths that follow it; the last count may run the
// same search; a lookup of a value below 256 goes through the entry ram read.
// one request is in flight at a time; its result waits while the output register is full.
// reset is synchronous and clears control state and the entry valid bits; no clearing pass.
`default_nettype none

module jpeg_huffman_table_builder_unit
    import jhtb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // item_value[8:0]
    input  wire logic [1:0]           s_tuser,   // req_type[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [47:0]          m_tdata,   // code_bits[30:0], code_size[35:31],
                                                 // entry_present[36], table_valid[37],
                                                 // load_error[40:38]
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_LOOK,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic                  kind_reg;
    logic [SYM_W-1:0]      max_sym_reg;

    logic [COUNT_W-1:0]    lc_reg [MAX_CODE_LENGTH];
    logic [COUNT_W-1:0]    lc_next [MAX_CODE_LENGTH];
    logic [COUNT_W-1:0]    total_reg, total_next;
    logic [RCODE_W-1:0]    code_reg, code_next;
    logic [LEN_W-1:0]      cnt_rcv_reg, cnt_rcv_next;
    logic [LEN_W-1:0]      cur_len_reg, cur_len_next;
    logic [COUNT_W-1:0]    left_reg, left_next;
    logic [COUNT_W-1:0]    syms_reg, syms_next;
    err_t                  err_reg, err_next;
    logic [MAX_SYMBOLS-1:0] vld_reg, vld_next;

    logic [ECODE_W-1:0]    res_code_reg, res_code_next;
    logic [ESIZE_W-1:0]    res_size_reg, res_size_next;
    logic                  res_pres_reg, res_pres_next;

    logic                  m_valid_reg, m_valid_next;
    logic [47:0]           m_data_reg, m_data_next;

    logic                  s_acc;
    req_t                  req;
    logic [VAL_W-1:0]      val;
    logic [SYM_W-1:0]      sym;
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [COUNT_W:0]      sum_total;
    logic [RCODE_W:0]      nxt_code;
    logic [RCODE_W:0]      len_limit;
    logic [LEN_W-1:0]      new_len;
    logic [VBITS_W-1:0]    vbits;
    logic [ECODE_W:0]      shifted;
    logic [COUNT_W-1:0]    left_dec;
    logic [COUNT_W-1:0]    syms_inc;
    logic                  tbl_valid;
    logic                  out_free;

    assign s_acc    = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser[1:0]);
    assign val      = s_tdata[VAL_W-1:0];
    assign sym      = val[SYM_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign sum_total = {1'b0, total_reg} + {1'b0, val[COUNT_W-1:0]};
    assign new_len   = cnt_rcv_reg + LEN_W'(1);
    assign nxt_code  = {1'b0, code_reg} + (RCODE_W + 1)'(val[COUNT_W-1:0]);
    assign len_limit = (RCODE_W + 1)'(1) << new_len;
    assign vbits     = val[VBITS_W-1:0];
    assign shifted   = (ECODE_W + 1)'(code_reg) << vbits;
    assign left_dec  = (left_reg != '0) ? left_reg - COUNT_W'(1) : '0;
    assign syms_inc  = syms_reg + COUNT_W'(1);
    assign ram_wdata = {ESIZE_W'(cur_len_reg + LEN_W'(vbits)), shifted[ECODE_W-1:0]};
    assign tbl_valid = (err_reg == ERR_NONE) && (cnt_rcv_reg >= LEN_LAST) &&
                       (syms_reg == total_reg);

    jhtb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SYMBOLS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (sym),
        .wr_data (ram_wdata),
        .rd_addr (sym),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        lc_next       = lc_reg;
        total_next    = total_reg;
        code_next     = code_reg;
        cnt_rcv_next  = cnt_rcv_reg;
        cur_len_next  = cur_len_reg;
        left_next     = left_reg;
        syms_next     = syms_reg;
        err_next      = err_reg;
        vld_next      = vld_reg;
        res_code_next = res_code_reg;
        res_size_next = res_size_reg;
        res_pres_next = res_pres_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    res_code_next = '0;
                    res_size_next = '0;
                    res_pres_next = 1'b0;
                    state_next    = ST_DONE;
                    unique case (req)
                        REQ_START: begin
                            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                                lc_next[i] = '0;
                            end
                            total_next   = '0;
                            code_next    = '0;
                            cnt_rcv_next = '0;
                            cur_len_next = LEN_W'(1);
                            left_next    = '0;
                            syms_next    = '0;
                            err_next     = ERR_NONE;
                            vld_next     = '0;
                        end
                        REQ_COUNT: begin
                            if (err_reg == ERR_NONE) begin
                                if (cnt_rcv_reg >= LEN_LAST) begin
                                    err_next = ERR_ORDER;
                                end else if (sum_total > SYM_LIMIT) begin
                                    err_next = ERR_OVERRUN;
                                end else if (val[COUNT_W-1:0] != '0 && nxt_code >= len_limit) begin
                                    err_next = ERR_OVERFLOW;
                                end else begin
                                    lc_next[cnt_rcv_reg[LIDX_W-1:0]] = val[COUNT_W-1:0];
                                    total_next   = sum_total[COUNT_W-1:0];
                                    code_next    = {nxt_code[RCODE_W-2:0], 1'b0};
                                    cnt_rcv_next = new_len;
                                    cur_len_next = new_len + LEN_W'(1);
                                    if (new_len == LEN_LAST) begin
                                        code_next    = '0;
                                        syms_next    = '0;
                                        cur_len_next = LEN_W'(1);
                                        left_next    = lc_next[0];
                                        if (lc_next[0] == '0 && sum_total[COUNT_W-1:0] != '0) begin
                                            state_next = ST_ADV;
                                        end
                                    end
                                end
                            end
                        end
                        REQ_SYMBOL: begin
                            if (err_reg == ERR_NONE) begin
                                if (cnt_rcv_reg < LEN_LAST || syms_reg >= total_reg) begin
                                    err_next = ERR_ORDER;
                                end else if (val[SYM_W] || sym > max_sym_reg ||
                                             (!kind_reg && sym[SYM_W-1:VBITS_W] != '0)) begin
                                    err_next = ERR_RANGE;
                                end else if (vld_reg[sym]) begin
                                    err_next = ERR_DUP;
                                end else begin
                                    ram_we        = 1'b1;
                                    vld_next[sym] = 1'b1;
                                    code_next     = code_reg + RCODE_W'(1);
                                    left_next     = left_dec;
                                    syms_next     = syms_inc;
                                    if (left_dec == '0 && syms_inc < total_reg) begin
                                        state_next = ST_ADV;
                                    end
                                end
                            end
                        end
                        REQ_LOOKUP: begin
                            if (!val[SYM_W]) begin
                                res_pres_next = vld_reg[sym];
                                state_next    = ST_LOOK;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADV: begin
                // one code length per cycle, code doubles per length passed
                if (cur_len_reg < LEN_LAST) begin
                    cur_len_next = cur_len_reg + LEN_W'(1);
                    code_next    = {code_reg[RCODE_W-2:0], 1'b0};
                    if (lc_reg[cur_len_reg[LIDX_W-1:0]] != '0) begin
                        left_next  = lc_reg[cur_len_reg[LIDX_W-1:0]];
                        state_next = ST_DONE;
                    end
                end else begin
                    left_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_LOOK: begin
                if (res_pres_reg) begin
                    res_code_next = ram_rdata[ECODE_W-1:0];
                    res_size_next = ram_rdata[ENTRY_W-1:ECODE_W];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, err_reg, tbl_valid, res_pres_reg,
                                    res_size_reg, res_code_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= 1'b0;
            max_sym_reg <= '1;
            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                lc_reg[i] <= '0;
            end
            total_reg    <= '0;
            code_reg     <= '0;
            cnt_rcv_reg  <= '0;
            cur_len_reg  <= LEN_W'(1);
            left_reg     <= '0;
            syms_reg     <= '0;
            err_reg      <= ERR_NONE;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
            res_pres_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_TABLE_KIND: kind_reg    <= cfg_data[0];
                    CFG_MAX_SYMBOL: max_sym_reg <= cfg_data;
                    default:        kind_reg    <= kind_reg;
                endcase
            end
            lc_reg       <= lc_next;
            total_reg    <= total_next;
            code_reg     <= code_next;
            cnt_rcv_reg  <= cnt_rcv_next;
            cur_len_reg  <= cur_len_next;
            left_reg     <= left_next;
            syms_reg     <= syms_next;
            err_reg      <= err_next;
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
            res_pres_reg <= res_pres_next;
        end
        res_code_reg <= res_code_next;
        res_size_reg <= res_size_next;
        m_data_reg   <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE && !(s_acc && req == REQ_START)) |=> err_reg != ERR_NONE)
        else $error("load error cleared without a start request");

    a_syms_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        syms_reg <= total_reg)
        else $error("more symbols placed than counted");

    a_look_follows_req: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOK |-> $past(s_acc) && $past(req) == REQ_LOOKUP)
        else $error("ram read state without a lookup request");

    a_adv_in_symbol_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADV |-> cnt_rcv_reg == LEN_LAST && cur_len_reg <= LEN_LAST)
        else $error("length search outside the symbol phase");
`endif

endmodule

`default_nettype wire

// ===== bench/jhtb_checker.sv =====
// jhtb_checker: watches the request and response streams of the huffman table builder,
// predicts each response from its own copy of the table state and compares field by field
// depends on jhtb_pkg
`timescale 1ns / 1ps

module jhtb_checker
    import jhtb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              drain_done,
    output int                mismatches,
    output int                outstanding,
    output int                responses_checked,
    output int                tables_completed
);

    typedef struct packed {
        err_t         load_error;
        logic         table_valid;
        logic         entry_present;
        logic [4:0]   code_size;
        logic [30:0]  code_bits;
    } table_response_t;

    table_response_t pending_responses[$];

    int          kind_reg;
    int          max_sym_reg;
    int          len_count[MAX_CODE_LENGTH];
    int          sym_total;
    int          run_code;
    int          counts_seen;
    int          cur_len;
    int          left_len;
    int          syms_seen;
    err_t        err_state;
    logic [30:0] entry_code[256];
    logic [4:0]  entry_size[256];

    int fail_n;
    int checked_n;
    int tables_n;
    bit prev_valid;
    bit drain_checked;

    task automatic report(string msg);
        fail_n++;
        if (fail_n <= 50) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, longint got, longint want, int idx);
        if (got != want) begin
            report($sformatf("response %0d %s: got 0x%0h, expected 0x%0h", idx, name, got, want));
        end
    endtask

    function automatic void clear_table();
        for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            len_count[i] = 0;
        end
        for (int i = 0; i < 256; i++) begin
            entry_code[i] = '0;
            entry_size[i] = '0;
        end
        sym_total   = 0;
        run_code    = 0;
        counts_seen = 0;
        cur_len     = 1;
        left_len    = 0;
        syms_seen   = 0;
        err_state   = ERR_NONE;
    endfunction

    // move on to the next length that holds codes, doubling the code per length
    function automatic void next_length();
        int len;
        len = cur_len;
        while (len < MAX_CODE_LENGTH) begin
            len++;
            run_code = (run_code << 1) & 'h1FFFF;
            if (len_count[len-1] != 0) begin
                cur_len  = len;
                left_len = len_count[len-1];
                return;
            end
        end
        cur_len  = len;
        left_len = 0;
    endfunction

    function automatic table_response_t table_response(req_t req, logic [8:0] val);
        table_response_t r;
        int next;
        int vbits;
        r = '0;
        case (req)
            REQ_START: begin
                clear_table();
            end
            REQ_COUNT: begin
                if (err_state == ERR_NONE) begin
                    next = run_code + int'(val);
                    if (counts_seen >= MAX_CODE_LENGTH) begin
                        err_state = ERR_ORDER;
                    end else if (sym_total + int'(val) > MAX_SYMBOLS) begin
                        err_state = ERR_OVERRUN;
                    end else if (val != 0 && next >= (1 << (counts_seen + 1))) begin
                        err_state = ERR_OVERFLOW;
                    end else begin
                        len_count[counts_seen] = int'(val);
                        sym_total += int'(val);
                        run_code = (next << 1) & 'h1FFFF;
                        counts_seen++;
                        cur_len = counts_seen + 1;
                        if (counts_seen == MAX_CODE_LENGTH) begin
                            // symbol phase starts at the first length that has codes
                            run_code  = 0;
                            syms_seen = 0;
                            cur_len   = 1;
                            left_len  = len_count[0];
                            if (left_len == 0 && sym_total != 0) begin
                                next_length();
                            end
                        end
                    end
                end
            end
            REQ_SYMBOL: begin
                if (err_state == ERR_NONE) begin
                    if (counts_seen < MAX_CODE_LENGTH || syms_seen >= sym_total) begin
                        err_state = ERR_ORDER;
                    end else if (val > 255 || int'(val) > max_sym_reg ||
                                 (kind_reg == 0 && val > 15)) begin
                        err_state = ERR_RANGE;
                    end else if (entry_size[val[7:0]] != 0) begin
                        err_state = ERR_DUP;
                    end else begin
                        vbits = (kind_reg != 0) ? int'(val[3:0]) : int'(val);
                        entry_code[val[7:0]] = 31'(longint'(run_code) << vbits);
                        entry_size[val[7:0]] = 5'(cur_len + vbits);
                        run_code = (run_code + 1) & 'h1FFFF;
                        if (left_len != 0) begin
                            left_len--;
                        end
                        syms_seen++;
                        if (left_len == 0 && syms_seen < sym_total) begin
                            next_length();
                        end
                    end
                end
            end
            default: begin
                if (val <= 255 && entry_size[val[7:0]] != 0) begin
                    r.code_bits     = entry_code[val[7:0]];
                    r.code_size     = entry_size[val[7:0]];
                    r.entry_present = 1'b1;
                end
            end
        endcase
        r.table_valid = (err_state == ERR_NONE) && (counts_seen >= MAX_CODE_LENGTH) &&
                        (syms_seen == sym_total);
        r.load_error  = err_state;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        table_response_t got;
        table_response_t want;
        if (!aresetn) begin
            kind_reg    = 0;
            max_sym_reg = 255;
            clear_table();
            pending_responses.delete();
            prev_valid = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_idx_t'(cfg_index) == CFG_TABLE_KIND) begin
                    kind_reg = int'(cfg_data[0]);
                end else begin
                    max_sym_reg = int'(cfg_data);
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[40:0];
                if (pending_responses.size() == 0) begin
                    report("response with no request outstanding");
                end else begin
                    want = pending_responses.pop_front();
                    check_field("code_bits", got.code_bits, want.code_bits, checked_n);
                    check_field("code_size", got.code_size, want.code_size, checked_n);
                    check_field("entry_present", got.entry_present, want.entry_present,
                                checked_n);
                    check_field("table_valid", got.table_valid, want.table_valid, checked_n);
                    check_field("load_error", got.load_error, want.load_error, checked_n);
                    checked_n++;
                end
            end
            if (s_tvalid && s_tready) begin
                want = table_response(req_t'(s_tuser), s_tdata[8:0]);
                if (want.table_valid && !prev_valid) begin
                    tables_n++;
                end
                prev_valid = want.table_valid;
                pending_responses.push_back(want);
            end
            if (drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                if (pending_responses.size() != 0) begin
                    report($sformatf("%0d responses never arrived", pending_responses.size()));
                end
            end
        end
        mismatches        <= fail_n;
        outstanding       <= pending_responses.size();
        responses_checked <= checked_n;
        tables_completed  <= tables_n;
    end

endmodule

// ===== bench/tb_jpeg_huffman_table_builder_unit.sv =====
// tb_jpeg_huffman_table_builder_unit: stimulus and verdict for the huffman table builder
// drives table loads, broken loads, lookups and noise with random gaps and stalls
// depends on jhtb_pkg, jhtb_checker and the unit under test
`timescale 1ns / 1ps

module tb_jpeg_huffman_table_builder_unit;
    import jhtb_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        req_t req;
        int   value;
    } load_item_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              drain_done = 1'b0;

    int mismatches;
    int outstanding;
    int responses_checked;
    int tables_completed;

    int cycles     = 0;
    int rx_mode    = 0;
    int mode_left  = 0;
    int burst_left = 0;
    int req_seen[4];
    int rounds     = 0;

    jpeg_huffman_table_builder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jhtb_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .drain_done        (drain_done),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .responses_checked (responses_checked),
        .tables_completed  (tables_completed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // response side: stall pattern switches between free running, random and periodic
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((cycles % 8) >= 3);
        endcase
    end

    task automatic send(req_t r, int v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= r;
        s_tdata  <= 16'(v);
        do @(posedge aclk); while (!s_tready);
        req_seen[r]++;
    endtask

    // wait until every request has its response and the unit is quiet
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(int kind, int max_sym);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TABLE_KIND;
        cfg_data  <= CFG_W'(kind);
        @(posedge aclk);
        cfg_index <= CFG_MAX_SYMBOL;
        cfg_data  <= CFG_W'(max_sym);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int         kind;
        int         max_sym;
        int         lim;
        int         n;
        int         total;
        int         code;
        int         rem;
        int         cap;
        int         upper;
        int         c;
        int         flip_at;
        int         pos;
        int         other;
        int         tmp;
        int         random_items;
        int         big_rounds;
        int         cnt[MAX_CODE_LENGTH];
        int         pool[$];
        load_item_t plan[$];

        random_items = 0;
        big_rounds   = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: lookups on an empty table, one short and one long code, extra symbol
        set_config(0, 255);
        send(REQ_LOOKUP, 0);
        send(REQ_LOOKUP, 511);
        send(REQ_START, 0);
        for (int len = 1; len <= MAX_CODE_LENGTH; len++) begin
            send(REQ_COUNT, (len == 1 || len == MAX_CODE_LENGTH) ? 1 : 0);
        end
        send(REQ_SYMBOL, 15);
        send(REQ_SYMBOL, 0);
        send(REQ_SYMBOL, 3);
        send(REQ_LOOKUP, 15);
        send(REQ_COUNT, 1);

        while (random_items < RANDOM_ITEMS) begin
            settle();
            if (rounds < 4) begin
                kind    = rounds % 2;
                max_sym = (rounds < 2) ? 255 : 0;
            end else begin
                kind = $urandom_range(0, 1);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: max_sym = 255;
                    4:          max_sym = 0;
                    5:          max_sym = 15;
                    6:          max_sym = 16;
                    default:    max_sym = $urandom_range(0, 255);
                endcase
            end
            set_config(kind, max_sym);
            rounds++;

            if (rounds > 4 && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(5, 30)) begin
                    send(req_t'($urandom_range(0, 3)), $urandom_range(0, 511));
                    random_items++;
                end
                continue;
            end

            lim = (kind != 0) ? max_sym : ((max_sym < 15) ? max_sym : 15);
            if (kind != 0 && lim == 255 && big_rounds < 2 && $urandom_range(0, 7) == 0) begin
                n = 256;
                big_rounds++;
            end else begin
                case ($urandom_range(0, 9))
                    0:       n = 0;
                    1, 2:    n = $urandom_range(0, lim + 1);
                    default: n = $urandom_range(1, (lim + 1 < 24) ? lim + 1 : 24);
                endcase
            end

            pool.delete();
            for (int i = 0; i <= lim; i++) begin
                pool.push_back(i);
            end
            for (int i = pool.size() - 1; i > 0; i--) begin
                other     = $urandom_range(0, i);
                tmp       = pool[i];
                pool[i]   = pool[other];
                pool[other] = tmp;
            end

            total = 0;
            code  = 0;
            if (n == 256 && $urandom_range(0, 1) == 1) begin
                for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                    cnt[i] = (i == 8) ? 256 : 0;
                end
                total = 256;
            end else begin
                for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                    rem = n - total;
                    cap = (1 << (i + 1)) - 1 - code;
                    c   = 0;
                    if (rem > 0 && cap > 0) begin
                        if (i == MAX_CODE_LENGTH - 1) begin
                            c = (rem < cap) ? rem : cap;
                        end else if ($urandom_range(0, 2) == 0) begin
                            upper = ($urandom_range(0, 7) == 0) ? cap : cap / 2;
                            if (upper > rem) begin
                                upper = rem;
                            end
                            if (upper > 0) begin
                                c = $urandom_range(1, upper);
                            end
                        end
                    end
                    cnt[i] = c;
                    total += c;
                    code = (code + c) << 1;
                end
            end

            plan.delete();
            plan.push_back('{REQ_START, 0});
            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                plan.push_back('{REQ_COUNT, cnt[i]});
            end
            for (int i = 0; i < total; i++) begin
                plan.push_back('{REQ_SYMBOL, pool[i]});
            end

            // a quarter of the loads are broken in one place
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0: begin
                        plan[1 + $urandom_range(0, 15)].value = $urandom_range(0, 511);
                    end
                    1: begin
                        plan.insert(1 + $urandom_range(0, 15),
                                    '{REQ_SYMBOL, $urandom_range(0, 255)});
                    end
                    2: begin
                        if (total > 0) begin
                            plan[17 + $urandom_range(0, total - 1)].value =
                                $urandom_range(0, 511);
                        end
                    end
                    3: begin
                        if (total > 1) begin
                            pos   = $urandom_range(1, total - 1);
                            other = $urandom_range(0, pos - 1);
                            plan[17 + pos].value = plan[17 + other].value;
                        end
                    end
                    4: begin
                        plan.push_back('{($urandom_range(0, 1) == 0) ? REQ_COUNT : REQ_SYMBOL,
                                         $urandom_range(0, 511)});
                    end
                    default: begin
                        plan.delete($urandom_range(1, 16 + total));
                    end
                endcase
            end

            repeat ($urandom_range(2, 10)) begin
                case ($urandom_range(0, 4))
                    0, 1, 2: plan.push_back('{REQ_LOOKUP, (total > 0) ?
                                              pool[$urandom_range(0, total - 1)] :
                                              $urandom_range(0, 255)});
                    3:       plan.push_back('{REQ_LOOKUP, $urandom_range(0, 255)});
                    default: plan.push_back('{REQ_LOOKUP, $urandom_range(0, 511)});
                endcase
            end

            // now and then the table kind flips halfway through the symbols
            flip_at = (total > 2 && $urandom_range(0, 5) == 0) ? 17 + total / 2 : -1;
            for (int i = 0; i < plan.size(); i++) begin
                if (i == flip_at) begin
                    settle();
                    kind = 1 - kind;
                    set_config(kind, max_sym);
                end
                send(plan[i].req, plan[i].value);
                random_items++;
            end
        end

        settle();
        drain_done <= 1'b1;
        repeat (3) @(posedge aclk);
        $display("%0d requests over %0d rounds: %0d start, %0d count, %0d symbol, %0d lookup",
                 req_seen[0] + req_seen[1] + req_seen[2] + req_seen[3], rounds,
                 req_seen[0], req_seen[1], req_seen[2], req_seen[3]);
        $display("%0d responses checked, %0d tables loaded without error",
                 responses_checked, tables_completed);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
